@@ sv/ddo_pkg.sv @@
// Shared types, constants and the arctangent table for the odometry core.
// No dependencies; used by ddo_ctrl, ddo_datapath and the top level.
`default_nettype none

package ddo_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 192;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port.
    localparam logic CFG_WHEEL_RADIUS = 1'b0;
    localparam logic CFG_WHEEL_BASE   = 1'b1;

    localparam logic [15:0] WHEEL_RADIUS_RST = 16'd640;
    localparam logic [15:0] WHEEL_BASE_RST   = 16'd5120;

    // The turn-rate dividend is a 32-bit magnitude with eight fraction bits appended.
    localparam int DIV_STEPS  = 40;
    localparam int CORDIC_MAX = 32;

    localparam logic signed [33:0] CORDIC_GAIN   = 34'sh026DD3B6A;
    localparam logic [61:0]        INV_PI_SCALED = 62'h28BE60DB93910A54;
    localparam logic signed [49:0] POS_MAX       = 50'sh0007FFFFFFFFFFF;
    localparam logic signed [49:0] POS_MIN       = -50'sh0007FFFFFFFFFFF - 50'sd1;

    // Multiply-accumulate schedule selects.
    localparam logic [2:0] MAC_X_LO = 3'd0;
    localparam logic [2:0] MAC_X_HI = 3'd1;
    localparam logic [2:0] MAC_Y_LO = 3'd2;
    localparam logic [2:0] MAC_Y_HI = 3'd3;
    localparam logic [2:0] MAC_I_00 = 3'd4;
    localparam logic [2:0] MAC_I_01 = 3'd5;
    localparam logic [2:0] MAC_I_10 = 3'd6;
    localparam logic [2:0] MAC_I_11 = 3'd7;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       cordic_en;
        logic [4:0] cordic_idx;
        logic       prep;
        logic       mul;
        logic       mac;
        logic [2:0] mac_sel;
        logic       finish;
    } ddo_cmd_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:  val = 32'h20000000;
            5'd1:  val = 32'h12E4051E;
            5'd2:  val = 32'h09FB385B;
            5'd3:  val = 32'h051111D4;
            5'd4:  val = 32'h028B0D43;
            5'd5:  val = 32'h0145D7E1;
            5'd6:  val = 32'h00A2F61E;
            5'd7:  val = 32'h00517C55;
            5'd8:  val = 32'h0028BE53;
            5'd9:  val = 32'h00145F2F;
            5'd10: val = 32'h000A2F98;
            5'd11: val = 32'h000517CC;
            5'd12: val = 32'h00028BE6;
            5'd13: val = 32'h000145F3;
            5'd14: val = 32'h0000A2FA;
            5'd15: val = 32'h0000517D;
            5'd16: val = 32'h000028BE;
            5'd17: val = 32'h0000145F;
            5'd18: val = 32'h00000A30;
            5'd19: val = 32'h00000518;
            5'd20: val = 32'h0000028C;
            5'd21: val = 32'h00000146;
            5'd22: val = 32'h000000A3;
            5'd23: val = 32'h00000051;
            5'd24: val = 32'h00000029;
            5'd25: val = 32'h00000014;
            5'd26: val = 32'h0000000A;
            5'd27: val = 32'h00000005;
            5'd28: val = 32'h00000003;
            5'd29: val = 32'h00000001;
            5'd30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ sv/differential_drive_odometry_core.sv @@
// Top level of the differential-drive odometry core.
// Instantiates ddo_ctrl and ddo_datapath; uses ddo_pkg.
//
//  channel   direction  width  contents (lowest bits first)
//  s_*       in         48     left_wheel_rate, right_wheel_rate, step_time
//  m_*       out        192    pos_x, pos_y, heading, linear_speed, turn_rate
//  cfg_*     in         16     0 = wheel_radius, 1 = wheel_base
//
// One word passes through the accepting cycle, 40 divider steps with the CORDIC beside
// them, prepare, multiply, eight accumulate steps and finish. The next word is accepted
// in the cycle after the result is registered.
// Reset is synchronous and active low; it clears the pose and loads the defaults.
// A stalled result holds in the output register while the next word is taken; the
// following result then waits in the finish step until the held one is taken.
`default_nettype none

module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // left_wheel_rate[15:0], right_wheel_rate[31:16], step_time[47:32]
    input  wire [ddo_pkg::IN_TDATA_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // pos_x[47:0], pos_y[95:48], heading[127:96], linear_speed[159:128],
    // turn_rate[191:160]
    output logic [ddo_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  wire                                  cfg_wr_en,
    input  wire                                  cfg_index,
    input  wire [ddo_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

    ddo_pkg::ddo_cmd_t cmd;

    ddo_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd)
    );

    ddo_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .m_tdata  (m_tdata)
    );

    // A word starts a multi-cycle computation, so no second word follows at once.
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A waiting result must not be overwritten by the next pose update.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result changed");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

@@ sv/ddo_ctrl.sv @@
// Sequencer for the odometry core: accept, iterate, multiply, finish.
// Depends on ddo_pkg for the command struct and step counts.
`default_nettype none

module ddo_ctrl #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  wire               m_tready,
    output ddo_pkg::ddo_cmd_t cmd
);

    localparam int NSTEP = (CORDIC_STEPS > ddo_pkg::CORDIC_MAX) ? ddo_pkg::CORDIC_MAX
                                                                 : CORDIC_STEPS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_MAC  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // Divider and CORDIC share the step counter.
                cmd.div_step   = 1'b1;
                cmd.cordic_en  = (cnt_reg < 6'(NSTEP));
                cmd.cordic_idx = cnt_reg[4:0];
                cnt_next       = cnt_reg + 6'd1;
                if (cnt_reg == 6'(ddo_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac     = 1'b1;
                cmd.mac_sel = cnt_reg[2:0];
                cnt_next    = cnt_reg + 6'd1;
                if (cnt_reg[2:0] == ddo_pkg::MAC_I_11) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ddo_datapath.sv @@
// Datapath of the odometry core: speeds, turn-rate divider, CORDIC, shared
// multiplier and pose registers. Depends on ddo_pkg; driven by ddo_ctrl.
`default_nettype none

module ddo_datapath (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  ddo_pkg::ddo_cmd_t                    cmd,
    input  wire [ddo_pkg::IN_TDATA_W-1:0]        s_tdata,
    input  wire                                  cfg_wr_en,
    input  wire                                  cfg_index,
    input  wire [ddo_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    output logic [ddo_pkg::OUT_TDATA_W-1:0]      m_tdata
);

    logic [15:0] radius_reg, base_reg;

    logic signed [31:0] v_reg, w_reg;
    logic [15:0]        dt_reg;
    logic               num_neg_reg, num_zero_reg;
    logic [15:0]        rem_reg;
    logic [39:0]        quo_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic [46:0]        dm_reg, pm_reg;
    logic [31:0]        cm_reg, sm_reg;
    logic               sgn_x_reg, sgn_y_reg, p_neg_reg;
    logic [79:0]        accx_reg, accy_reg;
    logic [111:0]       acci_reg;
    logic signed [47:0] x_accum_reg, y_accum_reg;
    logic [31:0]        angle_accum_reg;
    logic signed [31:0] v_out_reg, w_out_reg;

    // Input word fields.
    logic signed [15:0] wl, wr;
    assign wl = $signed(s_tdata[15:0]);
    assign wr = $signed(s_tdata[31:16]);

    logic signed [16:0] r_s, wsum, wdiff;
    logic signed [33:0] sumr, diffr, diffr_abs;
    assign r_s       = $signed({1'b0, radius_reg});
    assign wsum      = 17'(wr) + 17'(wl);
    assign wdiff     = 17'(wr) - 17'(wl);
    assign sumr      = 34'(wsum) * 34'(r_s);
    assign diffr     = 34'(wdiff) * 34'(r_s);
    assign diffr_abs = diffr[33] ? -diffr : diffr;

    logic [1:0]  quad;
    logic        flip_in;
    logic [31:0] z_in;
    assign quad    = angle_accum_reg[31:30];
    assign flip_in = (quad == 2'd1) || (quad == 2'd2);
    assign z_in    = flip_in ? (angle_accum_reg - 32'h80000000) : angle_accum_reg;

    // Restoring divider step.
    logic [16:0] trial;
    logic        ge;
    logic [16:0] trial_sub;
    assign trial     = {rem_reg, quo_reg[39]};
    assign ge        = (trial >= {1'b0, base_reg});
    assign trial_sub = trial - {1'b0, base_reg};

    // CORDIC step.
    logic signed [33:0] xs, ys, atan_s;
    assign xs     = cx_reg >>> cmd.cordic_idx;
    assign ys     = cy_reg >>> cmd.cordic_idx;
    assign atan_s = $signed({2'b00, ddo_pkg::atan_lut(cmd.cordic_idx)});

    // Turn rate from the quotient, with saturation and the zero-base case.
    logic [39:0]        quo_neg;
    logic signed [31:0] w_calc;
    assign quo_neg = 40'd0 - quo_reg;
    always_comb begin
        priority if (base_reg == 16'd0) begin
            w_calc = num_zero_reg ? 32'sd0 : (num_neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF);
        end else if (!num_neg_reg) begin
            w_calc = (quo_reg > 40'h007FFFFFFF) ? 32'sh7FFFFFFF : $signed(quo_reg[31:0]);
        end else begin
            w_calc = (quo_reg > 40'h0080000000) ? 32'sh80000000 : $signed(quo_neg[31:0]);
        end
    end

    logic signed [33:0] cos_next, sin_next;
    assign cos_next = flip_reg ? -cx_reg : cx_reg;
    assign sin_next = flip_reg ? -cy_reg : cy_reg;

    // Distance and angle products.
    logic signed [16:0] dt_s;
    logic signed [48:0] dist_prod, pw, dist_abs, pw_abs;
    logic signed [33:0] cos_abs, sin_abs;
    assign dt_s      = $signed({1'b0, dt_reg});
    assign dist_prod = 49'(v_reg) * 49'(dt_s);
    assign pw        = 49'(w_reg) * 49'(dt_s);
    assign dist_abs  = dist_prod[48] ? -dist_prod : dist_prod;
    assign pw_abs    = pw[48] ? -pw : pw;
    assign cos_abs   = cos_reg[33] ? -cos_reg : cos_reg;
    assign sin_abs   = sin_reg[33] ? -sin_reg : sin_reg;

    // Shared 24 x 32 multiplier.
    logic [23:0]  mac_a;
    logic [31:0]  mac_b;
    logic [5:0]   mac_sh;
    logic [55:0]  mac_p;
    logic [111:0] mac_add;
    always_comb begin
        unique case (cmd.mac_sel)
            ddo_pkg::MAC_X_LO: begin
                mac_a = dm_reg[23:0]; mac_b = cm_reg; mac_sh = 6'd0;
            end
            ddo_pkg::MAC_X_HI: begin
                mac_a = {1'b0, dm_reg[46:24]}; mac_b = cm_reg; mac_sh = 6'd24;
            end
            ddo_pkg::MAC_Y_LO: begin
                mac_a = dm_reg[23:0]; mac_b = sm_reg; mac_sh = 6'd0;
            end
            ddo_pkg::MAC_Y_HI: begin
                mac_a = {1'b0, dm_reg[46:24]}; mac_b = sm_reg; mac_sh = 6'd24;
            end
            ddo_pkg::MAC_I_00: begin
                mac_a = pm_reg[23:0];
                mac_b = {1'b0, ddo_pkg::INV_PI_SCALED[30:0]}; mac_sh = 6'd0;
            end
            ddo_pkg::MAC_I_01: begin
                mac_a = pm_reg[23:0];
                mac_b = {1'b0, ddo_pkg::INV_PI_SCALED[61:31]}; mac_sh = 6'd31;
            end
            ddo_pkg::MAC_I_10: begin
                mac_a = {1'b0, pm_reg[46:24]};
                mac_b = {1'b0, ddo_pkg::INV_PI_SCALED[30:0]}; mac_sh = 6'd24;
            end
            default: begin
                mac_a = {1'b0, pm_reg[46:24]};
                mac_b = {1'b0, ddo_pkg::INV_PI_SCALED[61:31]}; mac_sh = 6'd55;
            end
        endcase
    end
    assign mac_p   = 56'(mac_a) * 56'(mac_b);
    assign mac_add = {56'd0, mac_p} << mac_sh;

    // Final position update with saturation.
    logic [40:0]        dxm, dym;
    logic signed [49:0] dx, dy, xsum, ysum;
    logic signed [47:0] x_new, y_new;
    logic [31:0]        inc_mag, inc;
    assign dxm  = accx_reg[78:38];
    assign dym  = accy_reg[78:38];
    assign dx   = sgn_x_reg ? -$signed({9'd0, dxm}) : $signed({9'd0, dxm});
    assign dy   = sgn_y_reg ? -$signed({9'd0, dym}) : $signed({9'd0, dym});
    assign xsum = 50'(x_accum_reg) + dx;
    assign ysum = 50'(y_accum_reg) + dy;
    always_comb begin
        priority if (xsum > ddo_pkg::POS_MAX) x_new = ddo_pkg::POS_MAX[47:0];
        else if (xsum < ddo_pkg::POS_MIN)     x_new = ddo_pkg::POS_MIN[47:0];
        else                                  x_new = xsum[47:0];
        priority if (ysum > ddo_pkg::POS_MAX) y_new = ddo_pkg::POS_MAX[47:0];
        else if (ysum < ddo_pkg::POS_MIN)     y_new = ddo_pkg::POS_MIN[47:0];
        else                                  y_new = ysum[47:0];
    end
    assign inc_mag = acci_reg[87:56];
    assign inc     = p_neg_reg ? (32'd0 - inc_mag) : inc_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg      <= ddo_pkg::WHEEL_RADIUS_RST;
            base_reg        <= ddo_pkg::WHEEL_BASE_RST;
            x_accum_reg     <= '0;
            y_accum_reg     <= '0;
            angle_accum_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ddo_pkg::CFG_WHEEL_RADIUS: radius_reg <= cfg_wdata;
                    default:                   base_reg   <= cfg_wdata;
                endcase
            end
            if (cmd.finish) begin
                x_accum_reg     <= x_new;
                y_accum_reg     <= y_new;
                angle_accum_reg <= angle_accum_reg + inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg        <= sumr[32:1];
            dt_reg       <= s_tdata[47:32];
            num_neg_reg  <= diffr[33];
            num_zero_reg <= (diffr == 34'sd0);
            rem_reg      <= '0;
            quo_reg      <= {diffr_abs[31:0], 8'd0};
            cx_reg       <= ddo_pkg::CORDIC_GAIN;
            cy_reg       <= '0;
            cz_reg       <= 34'($signed(z_in));
            flip_reg     <= flip_in;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? trial_sub[15:0] : trial[15:0];
            quo_reg <= {quo_reg[38:0], ge};
        end
        if (cmd.cordic_en) begin
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - atan_s;
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + atan_s;
            end
        end
        if (cmd.prep) begin
            w_reg   <= w_calc;
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
        if (cmd.mul) begin
            dm_reg    <= dist_abs[46:0];
            pm_reg    <= pw_abs[46:0];
            cm_reg    <= cos_abs[31:0];
            sm_reg    <= sin_abs[31:0];
            sgn_x_reg <= dist_prod[48] ^ cos_reg[33];
            sgn_y_reg <= dist_prod[48] ^ sin_reg[33];
            p_neg_reg <= pw[48];
            accx_reg  <= '0;
            accy_reg  <= '0;
            acci_reg  <= '0;
        end
        if (cmd.mac) begin
            unique case (cmd.mac_sel)
                ddo_pkg::MAC_X_LO, ddo_pkg::MAC_X_HI: accx_reg <= accx_reg + mac_add[79:0];
                ddo_pkg::MAC_Y_LO, ddo_pkg::MAC_Y_HI: accy_reg <= accy_reg + mac_add[79:0];
                default:                              acci_reg <= acci_reg + mac_add;
            endcase
        end
        if (cmd.finish) begin
            v_out_reg <= v_reg;
            w_out_reg <= w_reg;
        end
    end

    assign m_tdata = {w_out_reg, v_out_reg, angle_accum_reg, y_accum_reg, x_accum_reg};

endmodule

`default_nettype wire

@@ verif/differential_drive_odometry_core_tb.sv @@
// Self-checking testbench for differential_drive_odometry_core: drives wheel-rate words,
// predicts pose, speed and turn rate in fixed point, and compares every result word.
// Depends on ddo_pkg and the core RTL only.
`timescale 1ns / 100ps
`default_nettype none

module differential_drive_odometry_core_tb;

    localparam int LATENCY    = 60;
    localparam int STALL_MAX  = 200000;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        logic [15:0] step_time;
        logic signed [15:0] right_rate;
        logic signed [15:0] left_rate;
    } wheel_word_t;

    typedef struct packed {
        logic signed [31:0] turn_rate;
        logic signed [31:0] linear_speed;
        logic [31:0] heading;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_x;
    } pose_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ddo_pkg::IN_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ddo_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = ddo_pkg::CFG_WHEEL_RADIUS;
    logic [ddo_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    differential_drive_odometry_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state.
    logic [15:0] radius_q8;
    logic [15:0] base_q8;
    logic signed [47:0] x_pos;
    logic signed [47:0] y_pos;
    logic [31:0] angle;

    wheel_word_t pending_words[$];
    pose_word_t  expected_poses[$];
    int errors = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit hold_receiver = 1'b0;
    bit sender_paused = 1'b0;

    function automatic logic [31:0] arctan_step(input int i);
        logic [31:0] t[32] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
            32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    // Rotation-mode CORDIC giving cos and sin in Q1.30 for a binary angle.
    task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] a;
        longint z, xv, yv, xs, ys;
        bit flip;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        a = flip ? ang - 32'h80000000 : ang;
        z = longint'($signed(a));
        xv = 64'sh26DD3B6A;
        yv = 0;
        for (int i = 0; i < 24; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (z >= 0) begin
                xv -= ys; yv += xs; z -= longint'(arctan_step(i));
            end else begin
                xv += ys; yv -= xs; z += longint'(arctan_step(i));
            end
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endtask

    function automatic logic signed [47:0] add_sat48(input logic signed [47:0] p,
                                                     input logic signed [127:0] d);
        logic signed [127:0] sum;
        sum = 128'(p) + d;
        if (sum > 128'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
        if (sum < -128'sh800000000000) return 48'sh800000000000;
        return sum[47:0];
    endfunction

    function automatic logic signed [127:0] scale_trunc38(input logic signed [127:0] a,
                                                          input logic signed [127:0] b);
        logic signed [127:0] p;
        p = a * b;
        return (p < 0) ? -((-p) >>> 38) : (p >>> 38);
    endfunction

    task automatic predict_pose(input wheel_word_t w);
        longint wl, wr, dt, sum, v, num, tr, c, s, dist_prod, p;
        logic [127:0] mag;
        logic [31:0] inc;
        pose_word_t r;
        wl = longint'(w.left_rate);
        wr = longint'(w.right_rate);
        dt = longint'(w.step_time);
        sum = (wr + wl) * longint'(radius_q8);
        v = (sum >= 0) ? sum / 2 : -((-sum + 1) / 2);
        num = (wr - wl) * longint'(radius_q8) * 256;
        if (base_q8 == 0) tr = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
        else tr = num / longint'(base_q8);
        if (tr > 64'sd2147483647) tr = 64'sd2147483647;
        if (tr < -64'sd2147483648) tr = -64'sd2147483648;
        rotate_unit(angle, c, s);
        dist_prod = v * dt;
        x_pos = add_sat48(x_pos, scale_trunc38(128'(dist_prod), 128'(c)));
        y_pos = add_sat48(y_pos, scale_trunc38(128'(dist_prod), 128'(s)));
        p = tr * dt;
        mag = 128'(p < 0 ? -p : p) * 128'h28BE60DB93910A54;
        inc = mag[87:56];
        if (p < 0) inc = -inc;
        angle = angle + inc;
        r.pos_x = x_pos;
        r.pos_y = y_pos;
        r.heading = angle;
        r.linear_speed = v[31:0];
        r.turn_rate = tr[31:0];
        expected_poses.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch on word %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    // Driver: bursts of words from the pending queue with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_pose(wheel_word_t'(s_tdata));
                void'(pending_words.pop_front());
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered word until it is taken
            end else if (sender_paused) begin
                s_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_words[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receiver stall pattern.
    int stall_mode = 0;
    always @(posedge aclk) begin
        pose_word_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = pose_word_t'(m_tdata);
                if (expected_poses.size() == 0) begin
                    report_mismatch("unexpected word", 64'(got.heading), 64'd0);
                end else begin
                    want = expected_poses.pop_front();
                    if (got.pos_x !== want.pos_x)
                        report_mismatch("pos_x", 64'(got.pos_x), 64'(want.pos_x));
                    if (got.pos_y !== want.pos_y)
                        report_mismatch("pos_y", 64'(got.pos_y), 64'(want.pos_y));
                    if (got.heading !== want.heading)
                        report_mismatch("heading", 64'(got.heading), 64'(want.heading));
                    if (got.linear_speed !== want.linear_speed)
                        report_mismatch("linear_speed", 64'(got.linear_speed),
                                        64'(want.linear_speed));
                    if (got.turn_rate !== want.turn_rate)
                        report_mismatch("turn_rate", 64'(got.turn_rate), 64'(want.turn_rate));
                end
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: m_tready <= !hold_receiver;
                1: m_tready <= !hold_receiver && ($urandom_range(0, 3) != 0);
                default: m_tready <= !hold_receiver && ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles > STALL_MAX) begin
            $display("watchdog expired");
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic add_word(input logic [15:0] l, input logic [15:0] r, input logic [15:0] t);
        wheel_word_t w;
        w.left_rate = l;
        w.right_rate = r;
        w.step_time = t;
        pending_words.push_back(w);
    endtask

    task automatic add_random_word();
        case ($urandom_range(0, 5))
            0: add_word(16'($urandom), 16'($urandom), 16'($urandom));
            1: add_word($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF,
                        $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF, 16'($urandom));
            default: add_word(16'($signed($urandom_range(0, 2047)) - 1024),
                              16'($signed($urandom_range(0, 2047)) - 1024),
                              16'($urandom_range(0, 1023)));
        endcase
    endtask

    task automatic drain();
        wait (pending_words.size() == 0 && !s_tvalid);
        wait (expected_poses.size() == 0);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == ddo_pkg::CFG_WHEEL_RADIUS) radius_q8 = val;
        else base_q8 = val;
    endtask

    initial begin
        radius_q8 = ddo_pkg::WHEEL_RADIUS_RST;
        base_q8 = ddo_pkg::WHEEL_BASE_RST;
        x_pos = '0;
        y_pos = '0;
        angle = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, straight runs, spins and saturation.
        add_word(16'h0000, 16'h0000, 16'h0000);
        add_word(16'h0100, 16'h0100, 16'h0100);
        add_word(16'h7FFF, 16'h7FFF, 16'hFFFF);
        add_word(16'h8000, 16'h8000, 16'hFFFF);
        add_word(16'h8000, 16'h7FFF, 16'hFFFF);
        add_word(16'h7FFF, 16'h8000, 16'hFFFF);
        add_word(16'hFFFF, 16'h0001, 16'h0040);
        add_word(16'h0200, 16'h0400, 16'h0080);
        for (int i = 0; i < 6; i++) add_word(16'h7FFF, 16'h7FFF, 16'hFFFF);
        drain();

        // Extreme registers: largest radius drives positions to saturation.
        write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 16'hFFFF);
        write_reg(ddo_pkg::CFG_WHEEL_BASE, 16'h0001);
        for (int i = 0; i < 8; i++) add_word(16'h8000, 16'h7FFF, 16'hFFFF);
        for (int i = 0; i < 6; i++) add_word(16'h7FFF, 16'h7FFF, 16'hFFFF);
        drain();

        // Zero wheel base and zero radius.
        write_reg(ddo_pkg::CFG_WHEEL_BASE, 16'h0000);
        add_word(16'h0000, 16'h0100, 16'h0100);
        add_word(16'h0100, 16'h0000, 16'h0100);
        add_word(16'h0100, 16'h0100, 16'h0100);
        drain();
        write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 16'h0000);
        write_reg(ddo_pkg::CFG_WHEEL_BASE, 16'hFFFF);
        add_word(16'h7FFF, 16'h8000, 16'hFFFF);
        drain();

        // Random phases with varied geometry; one with a long receiver hold.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ddo_pkg::CFG_WHEEL_RADIUS, 16'($urandom_range(1, 2000)));
            write_reg(ddo_pkg::CFG_WHEEL_BASE, 16'($urandom_range(1, 9000)));
            if (ph == 2) begin
                hold_receiver = 1'b1;
                for (int i = 0; i < 225; i++) add_random_word();
                repeat (LONG_HOLD) @(posedge aclk);
                hold_receiver = 1'b0;
            end else begin
                for (int i = 0; i < 225; i++) add_random_word();
            end
            if (ph == 4) begin
                wait (pending_words.size() < 100);
                sender_paused = 1'b1;
                wait (expected_poses.size() == 0 && !(m_tvalid));
                sender_paused = 1'b0;
            end
            drain();
        end

        $display("Covered %0d result words over directed extremes, zero base and radius,",
                 results_seen);
        $display("and six random geometry phases with stalls on both sides.");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
sv/ddo_pkg.sv
sv/ddo_ctrl.sv
sv/ddo_datapath.sv
sv/differential_drive_odometry_core.sv
verif/differential_drive_odometry_core_tb.sv
